### rtl/laq_pkg.sv
package laq_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned STAT_W  = 2;

  // Operation codes carried in mode
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // Head and tail values reported for an empty queue
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

endpackage

### rtl/laq_in_if.sv
interface laq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [laq_pkg::WORD_W-1:0]    value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

### rtl/laq_out_if.sv
interface laq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [laq_pkg::STAT_W-1:0]           status;
  logic signed [laq_pkg::WORD_W-1:0]    front_value;
  logic signed [laq_pkg::WORD_W-1:0]    rear_value;
  logic [laq_pkg::COUNT_W-1:0]          count;
  logic                                 is_empty;

  modport source (output valid, output status, output front_value, output rear_value,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input front_value, input rear_value,
                  input count, input is_empty, output ready);
endinterface

### rtl/laq_ram.sv
module laq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/linear_array_queue_unit.sv
// Linear (non-circular) array queue of signed 32-bit words.
// Push and refused ops load their result into the output register when accepted;
//   a pop that leaves the queue non-empty first passes through FETCH (one RAM read of the new head).
// Throughput: one transaction per cycle for pushes while the result side keeps up (ready);
//   such a pop blocks new transactions until FETCH is done, set by the single registered read port of the slot RAM.
// Reset (rst_ni low, async): queue empty, head and tail at slot 0, no result pending.
module linear_array_queue_unit #(
  parameter int unsigned DEPTH = laq_pkg::DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  laq_in_if.sink    in_i,
  laq_out_if.source out_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Sequencer: IDLE takes transactions, FETCH waits on the RAM for the new head
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  logic state_q, state_d;

  // Queue control state
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             empty_q, empty_d;

  // Cached copies of the head and tail words, so only a pop needs to read the RAM
  logic signed [laq_pkg::WORD_W-1:0] front_q, front_d;
  logic signed [laq_pkg::WORD_W-1:0] rear_q, rear_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic [laq_pkg::STAT_W-1:0]        out_status_q, out_status_d;
  logic signed [laq_pkg::WORD_W-1:0] out_front_q, out_front_d;
  logic signed [laq_pkg::WORD_W-1:0] out_rear_q, out_rear_d;
  logic [laq_pkg::COUNT_W-1:0]       out_count_q, out_count_d;
  logic                              out_empty_q, out_empty_d;

  // RAM port
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [IDX_W-1:0]           ram_raddr;
  logic [laq_pkg::WORD_W-1:0] ram_rdata;

  logic             accept;
  logic             out_free;
  logic [laq_pkg::STAT_W-1:0] status;
  logic             need_fetch;
  logic [IDX_W:0]   cnt_next;
  logic [IDX_W:0]   cnt_cur;

  laq_ram #(
    .WIDTH (laq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output slot is free next cycle if empty now or being drained
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;

  // Element counts; empty queue always has head == tail == 0
  assign cnt_next = {1'b0, tail_d} - {1'b0, head_d} + (IDX_W+1)'(1);
  assign cnt_cur  = {1'b0, tail_q} - {1'b0, head_q} + (IDX_W+1)'(1);

  // Operation decode and next queue state
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    front_d    = front_q;
    rear_d     = rear_q;
    status     = laq_pkg::ST_DONE;
    need_fetch = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = tail_q + IDX_W'(1);
    ram_raddr  = head_q + IDX_W'(1);

    if (accept) begin
      if (in_i.mode == laq_pkg::MODE_PUSH) begin
        if (empty_q) begin
          head_d    = '0;
          tail_d    = '0;
          empty_d   = 1'b0;
          front_d   = in_i.value;
          rear_d    = in_i.value;
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (tail_q == LAST_IDX) begin
          status = laq_pkg::ST_OVERFLOW;
        end else begin
          tail_d = tail_q + IDX_W'(1);
          rear_d = in_i.value;
          ram_we = 1'b1;
        end
      end else begin
        if (empty_q) begin
          status = laq_pkg::ST_UNDERFLOW;
        end else if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else begin
          // new head word arrives from the RAM next cycle
          head_d     = head_q + IDX_W'(1);
          need_fetch = 1'b1;
        end
      end
    end else if (state_q == ST_FETCH) begin
      front_d = ram_rdata;
    end
  end

  // Sequencer and result register
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_front_d  = out_front_q;
    out_rear_d   = out_rear_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (need_fetch) begin
            state_d = ST_FETCH;
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = status;
            out_empty_d  = empty_d;
            if (empty_d) begin
              out_front_d = laq_pkg::EMPTY_WORD;
              out_rear_d  = laq_pkg::EMPTY_WORD;
              out_count_d = '0;
            end else begin
              out_front_d = front_d;
              out_rear_d  = rear_d;
              out_count_d = laq_pkg::COUNT_W'(cnt_next);
            end
          end
        end
      end
      ST_FETCH: begin
        // output slot was freed when the pop was accepted
        state_d      = ST_IDLE;
        out_valid_d  = 1'b1;
        out_status_d = laq_pkg::ST_DONE;
        out_front_d  = ram_rdata;
        out_rear_d   = rear_q;
        out_count_d  = laq_pkg::COUNT_W'(cnt_cur);
        out_empty_d  = 1'b0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    rear_q       <= rear_d;
    out_status_q <= out_status_d;
    out_front_q  <= out_front_d;
    out_rear_q   <= out_rear_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.front_value = out_front_q;
  assign out_o.rear_value  = out_rear_q;
  assign out_o.count       = out_count_q;
  assign out_o.is_empty    = out_empty_q;

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Everything the block reports after one push or pop
  typedef struct {
    logic [laq_pkg::STAT_W-1:0]        status;
    logic signed [laq_pkg::WORD_W-1:0] front_value;
    logic signed [laq_pkg::WORD_W-1:0] rear_value;
    logic [laq_pkg::COUNT_W-1:0]       count;
    logic                              is_empty;
  } queue_report_t;

  // Shadow copy of the linear queue plus the reports still owed by the block
  class queue_tracker;
    logic signed [laq_pkg::WORD_W-1:0] slots[laq_pkg::DEPTH];
    int unsigned              head;
    int unsigned              tail;
    bit                       empty;
    queue_report_t            owed_reports[$];
    int                       errors;

    function new();
      head   = 0;
      tail   = 0;
      empty  = 1'b1;
      errors = 0;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    // Apply one accepted transaction to the shadow queue and queue its report
    function void note_op(logic op, logic signed [laq_pkg::WORD_W-1:0] word);
      queue_report_t rep;
      rep.status = laq_pkg::ST_DONE;
      if (op == laq_pkg::MODE_PUSH) begin
        if (empty) begin
          head     = 0;
          tail     = 0;
          slots[0] = word;
          empty    = 1'b0;
        end else if (tail >= laq_pkg::DEPTH - 1) begin
          // tail at the last slot: refused even with free slots at the front
          rep.status = laq_pkg::ST_OVERFLOW;
        end else begin
          tail        = tail + 1;
          slots[tail] = word;
        end
      end else begin
        if (empty) begin
          rep.status = laq_pkg::ST_UNDERFLOW;
        end else if (head == tail) begin
          // last element gone: indices rewind, slots become reusable
          head  = 0;
          tail  = 0;
          empty = 1'b1;
        end else begin
          head = head + 1;
        end
      end
      if (empty) begin
        rep.front_value = laq_pkg::EMPTY_WORD;
        rep.rear_value  = laq_pkg::EMPTY_WORD;
        rep.count       = '0;
      end else begin
        rep.front_value = slots[head];
        rep.rear_value  = slots[tail];
        rep.count       = laq_pkg::COUNT_W'(tail - head + 1);
      end
      rep.is_empty = empty;
      owed_reports.push_back(rep);
    endfunction

    function void check_report(queue_report_t got);
      queue_report_t want;
      if (owed_reports.size() == 0) begin
        $error("unexpected result transaction, status %0d front %0d",
               got.status, got.front_value);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
        errors++;
      end
      if (got.rear_value !== want.rear_value) begin
        $error("rear_value: expected %0d, got %0d", want.rear_value, got.rear_value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        errors++;
      end
    endfunction
  endclass

  localparam int RANDOM_OPS  = 800;
  localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the whole run

  logic clk_i;
  logic rst_ni;

  laq_in_if  in_if();
  laq_out_if out_if();

  linear_array_queue_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  queue_tracker tracker;
  bit           no_idle;     // both sides stop idling while set
  int           ops_sent;
  int           cycle_count;

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset asserted at time zero, released once
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake or a missing result ends up here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Extremes show up often; otherwise a full random word
  function automatic logic signed [laq_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction after a random gap; valid only drops when a gap is drawn,
  // so back-to-back transactions keep it high without a second assignment.
  task automatic send_op(input logic op, input logic signed [laq_pkg::WORD_W-1:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= op;
    in_if.value <= word;
    // handshake seen with pre-edge values at the rising edge
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.note_op(op, word);
    ops_sent++;
  endtask

  // Hold off the sender until every owed report has come back; valid drops so the
  // last transaction is not taken a second time
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall before each transaction, none while no_idle is set
  initial begin
    queue_report_t got;
    int stall;
    out_if.ready = 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.status      = out_if.status;
      got.front_value = out_if.front_value;
      got.rear_value  = out_if.rear_value;
      got.count       = out_if.count;
      got.is_empty    = out_if.is_empty;
      tracker.check_report(got);
    end
  end

  // Stimulus
  initial begin
    int  n_push;
    int  n_pop;
    bit  drained_once;
    tracker      = new();
    no_idle      = 1'b0;
    ops_sent     = 0;
    drained_once = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mode   = laq_pkg::MODE_PUSH;
    in_if.value  = '0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);

    // Directed: underflow out of reset, push into empty, pop of the last element
    send_op(laq_pkg::MODE_POP,  32'sd0);
    send_op(laq_pkg::MODE_PUSH, 32'sh7fff_ffff);
    send_op(laq_pkg::MODE_POP,  32'sd0);
    // fill all slots with extreme words
    send_op(laq_pkg::MODE_PUSH, 32'sh8000_0000);
    send_op(laq_pkg::MODE_PUSH, -32'sd1);
    send_op(laq_pkg::MODE_PUSH, 32'sd0);
    send_op(laq_pkg::MODE_PUSH, 32'sd1);
    send_op(laq_pkg::MODE_PUSH, 32'sh5555_5555);
    send_op(laq_pkg::MODE_PUSH, 32'shaaaa_aaaa);
    send_op(laq_pkg::MODE_PUSH, 32'sd123);
    send_op(laq_pkg::MODE_PUSH, -32'sd456);
    // overflow when full, then again with free slots at the front
    send_op(laq_pkg::MODE_PUSH, 32'sd99);
    send_op(laq_pkg::MODE_POP,  32'sd0);
    send_op(laq_pkg::MODE_POP,  32'sd0);
    send_op(laq_pkg::MODE_PUSH, 32'sd7);
    // drain to empty, then underflow, then slots reused from zero
    repeat (6) send_op(laq_pkg::MODE_POP, 32'sd0);
    send_op(laq_pkg::MODE_POP,  32'sh7fff_ffff);
    send_op(laq_pkg::MODE_PUSH, 32'sd42);
    send_op(laq_pkg::MODE_PUSH, 32'sd43);

    // Random: mostly runs of pushes followed by runs of pops, so the queue fills,
    // overflows, drains and underflows repeatedly; some plain noise in between.
    while (ops_sent < RANDOM_OPS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (!drained_once && ops_sent > RANDOM_OPS / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        n_push = $urandom_range(1, 10);
        n_pop  = $urandom_range(1, 10);
        repeat (n_push) send_op(laq_pkg::MODE_PUSH, pick_word());
        repeat (n_pop)  send_op(laq_pkg::MODE_POP, pick_word());
      end else begin
        repeat ($urandom_range(1, 12)) send_op(logic'($urandom_range(0, 1)), pick_word());
      end
    end

    no_idle = 1'b0;
    wait_drained();
    // pops pass through a RAM fetch; give any stray result time to show up
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### linear_array_queue_unit.f
rtl/laq_pkg.sv
rtl/laq_in_if.sv
rtl/laq_out_if.sv
rtl/laq_ram.sv
rtl/linear_array_queue_unit.sv
sim/testbench.sv
